[design/sslw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sslw_pkg - shared definitions for the servo slew limiter
// Codes, field widths, reset values, channel entry layout and sequencer states.
// ----------------------------------------------------------------------------
package sslw_pkg;

	// Parameter defaults
	localparam int CHANNELS_DEF   = 16;
	localparam int GROUP_SIZE_DEF = 4;

	// Field widths
	localparam int PULSE_W   = 12;
	localparam int COUNT_W   = 16;
	localparam int IDLE_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Input command codes
	localparam logic [1:0] CMD_SET_LIMITS = 2'd0;
	localparam logic [1:0] CMD_PULSE      = 2'd1;
	localparam logic [1:0] CMD_TICK       = 2'd2;

	// Result kinds
	localparam logic [1:0] EV_PULSE = 2'd0;
	localparam logic [1:0] EV_SETUP = 2'd1;
	localparam logic [1:0] EV_LIMP  = 2'd2;
	localparam logic [1:0] EV_BAD   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLEW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WDOG = 2'd1;

	// Reset values
	localparam logic [PULSE_W-1:0] SLEW_RST  = 12'd20;
	localparam logic [COUNT_W-1:0] WDOG_RST  = 16'd0;
	localparam logic [PULSE_W-1:0] LOW_RST   = 12'd500;
	localparam logic [PULSE_W-1:0] HIGH_RST  = 12'd2500;
	localparam logic [IDLE_W-1:0]  IDLE_MAX  = 17'h1ffff;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hffff;

	// One channel's stored state
	typedef struct packed {
		logic [PULSE_W-1:0] low;
		logic [PULSE_W-1:0] high;
		logic [PULSE_W-1:0] target;
		logic [PULSE_W-1:0] current;
		logic [COUNT_W-1:0] count;
	} entry_t;

	localparam entry_t ENTRY_RST = '{
		low:     LOW_RST,
		high:    HIGH_RST,
		target:  '0,
		current: '0,
		count:   '0
	};

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_WALK,
		ST_ERR,
		ST_LIMP
	} state_t;

endpackage
`default_nettype wire

[design/servo_slew_limiter_watchdog.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// servo_slew_limiter_watchdog - multichannel servo slew limiter with watchdog
// Per-channel limits, targets, current pulses and at-limit counts live in one
// synchronous memory; a sequencer reads, updates and writes back one channel
// per cycle unless the output stalls, and walks armed channels on each tick.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  -------  ---------------------  ---------------------------------------------
//  in       in_valid / in_ready    cmd, channel, pulse_us, min_limit_us,
//                                  max_limit_us
//  out      out_valid / out_ready  event_kind, out_channel, out_pulse_us,
//                                  limit_tick_count, tripped, last
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
//  Set limits and pulse command: the accepted word is read, updated and written
//  back in ST_CMD. Tick: the walk steps from channel 0 up to the highest armed
//  one, one channel at a time; the single memory read port sets this.
//  Reset: no clearing pass; a valid bit per memory entry makes an unwritten
//  entry read as its reset value, so the block is ready right after reset.
//  A stalled output holds the sequencer in place; one result word may wait in
//  the output register while the next input word is accepted.
// ----------------------------------------------------------------------------
module servo_slew_limiter_watchdog #(
	parameter int CHANNELS   = sslw_pkg::CHANNELS_DEF,
	parameter int GROUP_SIZE = sslw_pkg::GROUP_SIZE_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input words
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     cmd,
	input  wire logic [3:0]                     channel,
	input  wire logic [sslw_pkg::PULSE_W-1:0]   pulse_us,
	input  wire logic [sslw_pkg::PULSE_W-1:0]   min_limit_us,
	input  wire logic [sslw_pkg::PULSE_W-1:0]   max_limit_us,
	// result words
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          event_kind,
	output logic [3:0]                          out_channel,
	output logic [sslw_pkg::PULSE_W-1:0]        out_pulse_us,
	output logic [sslw_pkg::COUNT_W-1:0]        limit_tick_count,
	output logic                                tripped,
	output logic                                last,
	// configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sslw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sslw_pkg::CFG_DAT_W-1:0] cfg_data
);

	localparam int CW     = $clog2(CHANNELS);
	localparam int GROUPS = (CHANNELS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam logic [4:0] CH_END = 5'(CHANNELS);

	// Registers
	sslw_pkg::state_t state_q, state_d;
	logic [1:0]                    cmd_q;
	logic [3:0]                    ch_q;
	logic [sslw_pkg::PULSE_W-1:0]  pulse_q, lo_q, hi_q;
	logic [sslw_pkg::PULSE_W-1:0]  slew_q;
	logic [sslw_pkg::COUNT_W-1:0]  wdog_q;
	logic [CHANNELS-1:0]           armed_q;
	logic                          any_armed_q;
	logic [GROUPS-1:0]             grp_rdy_q;
	logic [sslw_pkg::IDLE_W-1:0]   idle_q;
	logic                          trip_q;
	logic [CW-1:0]                 p_q;
	logic [CHANNELS-1:0]           ent_vld_q;
	logic                          out_valid_q;

	// Memory and its read register
	sslw_pkg::entry_t mem [CHANNELS];
	sslw_pkg::entry_t rdata_q;
	logic             rvld_q;

	// Combinational control
	logic                  in_fire, out_free, ch_bad;
	logic                  rd_en, wr_en;
	logic [CW-1:0]         rd_addr, wr_addr;
	sslw_pkg::entry_t      entry, wr_data;
	logic [sslw_pkg::IDLE_W-1:0] idle_inc;
	logic                  trip_now;
	logic [CW-1:0]         chi;
	logic [GW-1:0]         grp_idx;
	logic [3:0]            grp_base;
	logic                  need_setup, cmd_go;
	logic [CHANNELS-1:0]   above_mask;
	logic                  rest_armed, cur_armed, walk_go, walk_done;
	logic [sslw_pkg::PULSE_W-1:0] clamp_lo, clamp_v, set_lo, set_hi, cur_n;
	logic                  at_lim;
	logic [sslw_pkg::COUNT_W-1:0] cnt_n;
	logic                  out_load;
	logic [1:0]            ld_kind;
	logic [3:0]            ld_ch;
	logic [sslw_pkg::PULSE_W-1:0] ld_pulse;
	logic [sslw_pkg::COUNT_W-1:0] ld_cnt;
	logic                  ld_trip, ld_last;

	assign in_ready  = (state_q == sslw_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign ch_bad    = ({1'b0, channel} >= CH_END);
	assign chi       = ch_q[CW-1:0];

	// Advance the idle count and check the watchdog for an incoming tick
	assign idle_inc = (idle_q == sslw_pkg::IDLE_MAX) ? idle_q : idle_q + 1'b1;
	assign trip_now = (wdog_q != '0) && (idle_inc > {1'b0, wdog_q});

	// Substitute reset values for entries never written
	assign entry = rvld_q ? rdata_q : sslw_pkg::ENTRY_RST;

	// Look up group index and group base of the latched channel
	always_comb begin
		grp_idx  = '0;
		grp_base = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (chi == CW'(i)) begin
				grp_idx  = GW'(i / GROUP_SIZE);
				grp_base = 4'((i / GROUP_SIZE) * GROUP_SIZE);
			end
		end
	end

	// Clamp the command to the channel limits; order a set-limits pair
	always_comb begin
		clamp_lo = (pulse_q < entry.low) ? entry.low : pulse_q;
		clamp_v  = (clamp_lo > entry.high) ? entry.high : clamp_lo;
		set_lo   = (lo_q > hi_q) ? hi_q : lo_q;
		set_hi   = (lo_q > hi_q) ? lo_q : hi_q;
	end

	assign need_setup = !armed_q[chi] && !grp_rdy_q[grp_idx];

	// Move the walked channel toward its target and count time at a limit
	always_comb begin
		if (entry.target > entry.current) begin
			cur_n = (entry.target - entry.current > slew_q) ?
				entry.current + slew_q : entry.target;
		end else begin
			cur_n = (entry.current - entry.target > slew_q) ?
				entry.current - slew_q : entry.target;
		end
		at_lim = (cur_n <= entry.low) || (cur_n >= entry.high);
		cnt_n  = (at_lim && entry.count != sslw_pkg::COUNT_MAX) ?
			entry.count + 1'b1 : entry.count;
	end

	// Find whether any armed channel lies beyond the walk position
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			above_mask[i] = (CW'(i) > p_q);
		end
	end
	assign rest_armed = |(armed_q & above_mask);
	assign cur_armed  = armed_q[p_q];
	assign walk_done  = !rest_armed;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			sslw_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (cmd == sslw_pkg::CMD_SET_LIMITS || cmd == sslw_pkg::CMD_PULSE) begin
						state_d = ch_bad ? sslw_pkg::ST_ERR : sslw_pkg::ST_CMD;
					end else if (cmd == sslw_pkg::CMD_TICK && any_armed_q) begin
						state_d = trip_now ? sslw_pkg::ST_LIMP : sslw_pkg::ST_WALK;
					end
				end
			end
			sslw_pkg::ST_CMD: begin
				if (cmd_go) state_d = sslw_pkg::ST_IDLE;
			end
			sslw_pkg::ST_WALK: begin
				if (walk_go && walk_done) state_d = sslw_pkg::ST_IDLE;
			end
			sslw_pkg::ST_ERR, sslw_pkg::ST_LIMP: begin
				if (out_free) state_d = sslw_pkg::ST_IDLE;
			end
			default: state_d = sslw_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory access, result word, step strobes
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = p_q + 1'b1;
		wr_en    = 1'b0;
		wr_addr  = chi;
		wr_data  = entry;
		cmd_go   = 1'b0;
		walk_go  = 1'b0;
		out_load = 1'b0;
		ld_kind  = sslw_pkg::EV_PULSE;
		ld_ch    = '0;
		ld_pulse = '0;
		ld_cnt   = '0;
		ld_trip  = trip_q;
		ld_last  = 1'b1;
		unique case (state_q)
			sslw_pkg::ST_IDLE: begin
				if (in_fire && !ch_bad &&
					(cmd == sslw_pkg::CMD_SET_LIMITS || cmd == sslw_pkg::CMD_PULSE)) begin
					rd_en   = 1'b1;
					rd_addr = channel[CW-1:0];
				end else if (in_fire && cmd == sslw_pkg::CMD_TICK && any_armed_q &&
					!trip_now) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			sslw_pkg::ST_CMD: begin
				if (cmd_q == sslw_pkg::CMD_SET_LIMITS) begin
					cmd_go       = 1'b1;
					wr_en        = 1'b1;
					wr_data.low  = set_lo;
					wr_data.high = set_hi;
				end else begin
					cmd_go = !need_setup || out_free;
					wr_en  = cmd_go;
					wr_data.target = clamp_v;
					if (!armed_q[chi]) wr_data.current = clamp_v;
					if (need_setup && out_free) begin
						out_load = 1'b1;
						ld_kind  = sslw_pkg::EV_SETUP;
						ld_ch    = grp_base;
						ld_trip  = 1'b0;
					end
				end
			end
			sslw_pkg::ST_WALK: begin
				walk_go = !cur_armed || out_free;
				wr_addr = p_q;
				if (cur_armed && out_free) begin
					wr_en           = 1'b1;
					wr_data.current = cur_n;
					wr_data.count   = cnt_n;
					out_load        = 1'b1;
					ld_kind         = sslw_pkg::EV_PULSE;
					ld_ch           = 4'(p_q);
					ld_pulse        = cur_n;
					ld_cnt          = cnt_n;
					ld_last         = walk_done;
				end
				if (walk_go && !walk_done) rd_en = 1'b1;
			end
			sslw_pkg::ST_ERR: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_kind  = sslw_pkg::EV_BAD;
					ld_ch    = ch_q;
				end
			end
			sslw_pkg::ST_LIMP: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_kind  = sslw_pkg::EV_LIMP;
				end
			end
			default: begin
			end
		endcase
	end

	// Hold sequencer state and channel flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sslw_pkg::ST_IDLE;
			slew_q      <= sslw_pkg::SLEW_RST;
			wdog_q      <= sslw_pkg::WDOG_RST;
			armed_q     <= '0;
			any_armed_q <= 1'b0;
			grp_rdy_q   <= '0;
			idle_q      <= '0;
			trip_q      <= 1'b0;
			p_q         <= '0;
			ent_vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sslw_pkg::REG_SLEW: slew_q <= cfg_data[sslw_pkg::PULSE_W-1:0];
					sslw_pkg::REG_WDOG: wdog_q <= cfg_data;
					default: begin
					end
				endcase
			end
			// tick: count idle time, trip the watchdog or start the walk
			if (in_fire && cmd == sslw_pkg::CMD_TICK) begin
				idle_q <= idle_inc;
				p_q    <= '0;
				if (any_armed_q && trip_now) begin
					armed_q     <= '0;
					any_armed_q <= 1'b0;
					trip_q      <= 1'b1;
				end
			end
			// pulse command: arm the channel and restart the watchdog
			if (state_q == sslw_pkg::ST_CMD && cmd_go && cmd_q == sslw_pkg::CMD_PULSE) begin
				trip_q       <= 1'b0;
				idle_q       <= '0;
				armed_q[chi] <= 1'b1;
				any_armed_q  <= 1'b1;
				if (need_setup) grp_rdy_q[grp_idx] <= 1'b1;
			end
			if (walk_go && !walk_done) p_q <= p_q + 1'b1;
			if (wr_en) ent_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Latch the accepted input word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= cmd;
			ch_q    <= channel;
			pulse_q <= pulse_us;
			lo_q    <= min_limit_us;
			hi_q    <= max_limit_us;
		end
	end

	// Channel memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q <= 1'b0;
		end else if (rd_en) begin
			rvld_q <= ent_vld_q[rd_addr];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			event_kind       <= ld_kind;
			out_channel      <= ld_ch;
			out_pulse_us     <= ld_pulse;
			limit_tick_count <= ld_cnt;
			tripped          <= ld_trip;
			last             <= ld_last;
		end
	end

	assign out_valid = out_valid_q;

	// The summary flag tracks the per-channel armed bits
	a_any_armed: assert property (@(posedge clk) disable iff (!arst_n)
		any_armed_q == (|armed_q))
		else $error("any_armed out of step with armed bits");

	// A tripped watchdog leaves every channel disarmed
	a_trip_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		trip_q |-> (armed_q == '0))
		else $error("channel armed while watchdog tripped");

	// A tick walk only runs with some channel armed
	a_walk_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sslw_pkg::ST_WALK) |-> any_armed_q)
		else $error("walk with no armed channel");

	// Each write-back during a walk emits exactly one pulse word
	a_walk_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sslw_pkg::ST_WALK && wr_en) |-> (out_load && wr_addr == p_q))
		else $error("walk write-back without pulse word");

	// A group setup marks the group ready for later commands
	a_grp_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sslw_pkg::ST_CMD && cmd_q == sslw_pkg::CMD_PULSE && cmd_go && need_setup)
		|=> grp_rdy_q[$past(grp_idx)])
		else $error("group setup not recorded");

endmodule
`default_nettype wire

[dv/slew_event_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slew_event_checker - result predictor and scoreboard for the servo limiter
// Watches the input, result and configuration channels of the block, keeps its
// own copy of the per-channel limits, targets, pulses and counters, predicts
// the result words that each accepted input word causes and compares every
// accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module slew_event_checker
	import sslw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input words
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [3:0]         channel,
	input  logic [PULSE_W-1:0] pulse_us,
	input  logic [PULSE_W-1:0] min_limit_us,
	input  logic [PULSE_W-1:0] max_limit_us,
	// result words
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         event_kind,
	input  logic [3:0]         out_channel,
	input  logic [PULSE_W-1:0] out_pulse_us,
	input  logic [COUNT_W-1:0] limit_tick_count,
	input  logic               tripped,
	input  logic               last,
	// configuration writes
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// status for the test top
	output int                 fail_count,
	output int                 pending,
	output int                 result_count,
	output int                 limp_count
);

	localparam int NCH  = CHANNELS_DEF;
	localparam int GSZ  = GROUP_SIZE_DEF;
	localparam int NGRP = (NCH + GSZ - 1) / GSZ;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         ch;
		logic [PULSE_W-1:0] pulse;
		logic [COUNT_W-1:0] cnt;
		logic               trip;
		logic               is_last;
	} servo_ev_t;

	servo_ev_t servo_events_due[$];

	// predicted block state
	logic [PULSE_W-1:0] slew_step;
	logic [COUNT_W-1:0] wdog_limit;
	logic [PULSE_W-1:0] low_lim [NCH];
	logic [PULSE_W-1:0] high_lim [NCH];
	logic [PULSE_W-1:0] tgt_pulse [NCH];
	logic [PULSE_W-1:0] cur_pulse [NCH];
	logic [COUNT_W-1:0] at_lim_cnt [NCH];
	logic [NCH-1:0]     armed_mask;
	logic [NGRP-1:0]    group_ready;
	logic               any_armed;
	logic [IDLE_W-1:0]  idle_ticks;
	logic               trip_flag;

	task automatic clear_state();
		slew_step   = SLEW_RST;
		wdog_limit  = WDOG_RST;
		armed_mask  = '0;
		group_ready = '0;
		any_armed   = 1'b0;
		idle_ticks  = '0;
		trip_flag   = 1'b0;
		for (int i = 0; i < NCH; i++) begin
			low_lim[i]    = LOW_RST;
			high_lim[i]   = HIGH_RST;
			tgt_pulse[i]  = '0;
			cur_pulse[i]  = '0;
			at_lim_cnt[i] = '0;
		end
	endtask

	task automatic post_event(input logic [1:0] kind, input logic [3:0] ch,
			input logic [PULSE_W-1:0] pulse, input logic [COUNT_W-1:0] cnt,
			input logic is_last);
		servo_ev_t ev;
		ev.kind    = kind;
		ev.ch      = ch;
		ev.pulse   = pulse;
		ev.cnt     = cnt;
		ev.trip    = trip_flag;
		ev.is_last = is_last;
		servo_events_due.push_back(ev);
	endtask

	// Advance the predicted state by one input word and queue its results
	task automatic predict_servo_events(input logic [1:0] c, input logic [3:0] ch,
			input logic [PULSE_W-1:0] us, input logic [PULSE_W-1:0] lo,
			input logic [PULSE_W-1:0] hi);
		logic [PULSE_W-1:0] a;
		logic [PULSE_W-1:0] b;
		logic [PULSE_W-1:0] clamp;
		int g;
		int top_ch;
		int cur;
		int tgt;
		int step;
		a = lo;
		b = hi;
		case (c)
			CMD_SET_LIMITS, CMD_PULSE: begin
				if (int'(ch) >= NCH) begin
					post_event(EV_BAD, ch, '0, '0, 1'b1);
				end else if (c == CMD_SET_LIMITS) begin
					// swap reversed limits
					if (a > b) begin
						a = hi;
						b = lo;
					end
					low_lim[ch]  = a;
					high_lim[ch] = b;
				end else begin
					clamp = us;
					if (clamp < low_lim[ch])
						clamp = low_lim[ch];
					if (clamp > high_lim[ch])
						clamp = high_lim[ch];
					trip_flag  = 1'b0;
					idle_ticks = '0;
					// jump to the target on first arming
					if (!armed_mask[ch]) begin
						cur_pulse[ch] = clamp;
						g = int'(ch) / GSZ;
						if (g < NGRP && !group_ready[g]) begin
							group_ready[g] = 1'b1;
							post_event(EV_SETUP, 4'(g * GSZ), '0, '0, 1'b1);
						end
					end
					tgt_pulse[ch]  = clamp;
					armed_mask[ch] = 1'b1;
					any_armed      = 1'b1;
				end
			end
			CMD_TICK: begin
				if (idle_ticks < IDLE_MAX)
					idle_ticks = idle_ticks + 1'b1;
				if (any_armed) begin
					if (wdog_limit != '0 && idle_ticks > {1'b0, wdog_limit}) begin
						// trip: drop every channel
						armed_mask = '0;
						any_armed  = 1'b0;
						trip_flag  = 1'b1;
						post_event(EV_LIMP, '0, '0, '0, 1'b1);
					end else begin
						top_ch = -1;
						for (int i = 0; i < NCH; i++)
							if (armed_mask[i])
								top_ch = i;
						step = int'(slew_step);
						// move each armed channel toward its target
						for (int i = 0; i < NCH; i++) begin
							if (armed_mask[i]) begin
								cur = int'(cur_pulse[i]);
								tgt = int'(tgt_pulse[i]);
								if (tgt > cur)
									cur = (tgt - cur > step) ? cur + step : tgt;
								else
									cur = (cur - tgt > step) ? cur - step : tgt;
								cur_pulse[i] = PULSE_W'(cur);
								if ((cur_pulse[i] <= low_lim[i] || cur_pulse[i] >= high_lim[i])
										&& at_lim_cnt[i] < COUNT_MAX)
									at_lim_cnt[i] = at_lim_cnt[i] + 1'b1;
								post_event(EV_PULSE, 4'(i), cur_pulse[i], at_lim_cnt[i],
									i == top_ch);
							end
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Compare result words first, then predict from the input word
	always @(posedge clk or negedge arst_n) begin
		servo_ev_t ev;
		if (!arst_n) begin
			clear_state();
			servo_events_due.delete();
			fail_count   = 0;
			pending      = 0;
			result_count = 0;
			limp_count   = 0;
		end else begin
			if (out_valid && out_ready) begin
				result_count++;
				if (servo_events_due.size() == 0) begin
					$display("%0t ns: result word with none expected, kind %0d channel %0d",
						$time, event_kind, out_channel);
					fail_count++;
				end else begin
					ev = servo_events_due.pop_front();
					check_field("event_kind", ev.kind, event_kind);
					check_field("out_channel", ev.ch, out_channel);
					check_field("out_pulse_us", ev.pulse, out_pulse_us);
					check_field("limit_tick_count", ev.cnt, limit_tick_count);
					check_field("tripped", ev.trip, tripped);
					check_field("last", ev.is_last, last);
					if (ev.kind == EV_LIMP)
						limp_count++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SLEW)
					slew_step = cfg_data[PULSE_W-1:0];
				else if (cfg_index == REG_WDOG)
					wdog_limit = cfg_data;
			end
			if (in_valid && in_ready)
				predict_servo_events(cmd, channel, pulse_us, min_limit_us, max_limit_us);
			pending = servo_events_due.size();
		end
	end

endmodule

[dv/servo_slew_limiter_watchdog_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_slew_limiter_watchdog_test - top of the servo slew limiter testbench
// Drives set-limits, pulse command and tick words with random idling on both
// channels across several slew and watchdog settings, then drives one channel
// alone pinned at its limits and runs it into a short watchdog trip.
// The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module servo_slew_limiter_watchdog_test;
	import sslw_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         PHASE_WORDS  = 90;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         STALL_LIMIT  = 2000;
	localparam int         LIMIT_TICKS  = 10;
	localparam int         WDOG_TICKS   = 9;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic [3:0]         channel;
	logic [PULSE_W-1:0] pulse_us;
	logic [PULSE_W-1:0] min_limit_us;
	logic [PULSE_W-1:0] max_limit_us;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         event_kind;
	logic [3:0]         out_channel;
	logic [PULSE_W-1:0] out_pulse_us;
	logic [COUNT_W-1:0] limit_tick_count;
	logic               tripped;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	int fail_count;
	int pending;
	int result_count;
	int limp_count;
	int word_count   = 0;
	int settings     = 0;
	int quiet_cycles = 0;
	int stall_left   = 0;
	bit idling_on    = 1'b1;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	servo_slew_limiter_watchdog dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.channel          (channel),
		.pulse_us         (pulse_us),
		.min_limit_us     (min_limit_us),
		.max_limit_us     (max_limit_us),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_kind       (event_kind),
		.out_channel      (out_channel),
		.out_pulse_us     (out_pulse_us),
		.limit_tick_count (limit_tick_count),
		.tripped          (tripped),
		.last             (last),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	slew_event_checker events_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.channel          (channel),
		.pulse_us         (pulse_us),
		.min_limit_us     (min_limit_us),
		.max_limit_us     (max_limit_us),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_kind       (event_kind),
		.out_channel      (out_channel),
		.out_pulse_us     (out_pulse_us),
		.limit_tick_count (limit_tick_count),
		.tripped          (tripped),
		.last             (last),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.pending          (pending),
		.result_count     (result_count),
		.limp_count       (limp_count)
	);

	// Stall the result side in random bursts, only while idling is on
	always @(posedge clk) begin
		if (!idling_on) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// End the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("servo_slew_limiter_watchdog_test failed");
			$finish;
		end
	end

	// Present one input word and hold it until accepted
	task automatic send_word(input logic [1:0] c, input logic [3:0] ch,
			input logic [PULSE_W-1:0] us, input logic [PULSE_W-1:0] lo,
			input logic [PULSE_W-1:0] hi);
		bit taken;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		channel      <= ch;
		pulse_us     <= us;
		min_limit_us <= lo;
		max_limit_us <= hi;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		if (c != CMD_UNUSED)
			word_count++;
	endtask

	// Drop valid, wait for all results, then let a late tick walk finish
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back; call only while idle
	task automatic write_regs(input logic [15:0] slew_data, input logic [15:0] wdog_data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= REG_SLEW;
		cfg_data  <= slew_data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_index <= REG_WDOG;
		cfg_data  <= wdog_data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	function automatic logic [PULSE_W-1:0] pick_pulse();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return PULSE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// Mostly ticks and commands, some limit changes, a little unused code
	task automatic random_word();
		int pick;
		logic [1:0] c;
		logic [PULSE_W-1:0] lo;
		logic [PULSE_W-1:0] hi;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			c = CMD_TICK;
		else if (pick < 78)
			c = CMD_PULSE;
		else if (pick < 95)
			c = CMD_SET_LIMITS;
		else
			c = CMD_UNUSED;
		if (c == CMD_SET_LIMITS && $urandom_range(0, 3) != 0) begin
			lo = PULSE_W'($urandom_range(0, 2000));
			hi = PULSE_W'($urandom_range(lo, 4095));
		end else begin
			lo = pick_pulse();
			hi = pick_pulse();
		end
		send_word(c, 4'($urandom_range(0, 15)), pick_pulse(), lo, hi);
	endtask

	initial begin
		int start;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = CMD_TICK;
		channel      = '0;
		pulse_us     = '0;
		min_limit_us = '0;
		max_limit_us = '0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_SLEW;
		cfg_data     = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at reset settings
		send_word(CMD_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
		send_word(CMD_SET_LIMITS, 4'd0, 12'd0, 12'd3000, 12'd1000);
		send_word(CMD_SET_LIMITS, 4'd15, 12'd4095, 12'd0, 12'd4095);
		send_word(CMD_SET_LIMITS, 4'd5, 12'd0, 12'd1500, 12'd1500);
		send_word(CMD_PULSE, 4'd0, 12'd0, 12'd0, 12'd0);
		send_word(CMD_PULSE, 4'd15, 12'd4095, 12'd0, 12'd0);
		send_word(CMD_PULSE, 4'd5, 12'd4095, 12'd0, 12'd0);
		send_word(CMD_PULSE, 4'd1, 12'd2000, 12'd0, 12'd0);
		send_word(CMD_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
		send_word(CMD_UNUSED, 4'd15, 12'd4095, 12'd4095, 12'd4095);
		send_word(CMD_PULSE, 4'd0, 12'd4095, 12'd0, 12'd0);
		send_word(CMD_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
		send_word(CMD_TICK, 4'd15, 12'd4095, 12'd4095, 12'd4095);
		send_word(CMD_PULSE, 4'd9, 12'd700, 12'd0, 12'd0);
		send_word(CMD_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
		send_word(CMD_SET_LIMITS, 4'd1, 12'd0, 12'd4095, 12'd0);
		send_word(CMD_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
		settle();

		// random words under several settings
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_regs(16'd0, 16'd3);
				1: write_regs(16'hffff, 16'd0);
				2: write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 24)));
				default: write_regs(16'd1, 16'd1);
			endcase
			idling_on = (phase != 1);
			start = word_count;
			while (word_count - start < PHASE_WORDS)
				random_word();
			settle();
		end

		// disarm everything, then drive channel 0 alone with no idling
		idling_on = 1'b0;
		send_word(CMD_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
		send_word(CMD_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
		settle();
		write_regs(16'd4095, 16'd0);
		send_word(CMD_SET_LIMITS, 4'd0, 12'd0, 12'd200, 12'd100);
		send_word(CMD_PULSE, 4'd0, 12'd4095, 12'd0, 12'd0);
		for (int i = 0; i < LIMIT_TICKS; i++)
			send_word(CMD_TICK, 4'($urandom_range(0, 15)), 12'd0, 12'd0, 12'd0);
		settle();

		// short watchdog limit: trip on the tick after the limit
		write_regs(16'd4095, 16'd8);
		send_word(CMD_PULSE, 4'd0, 12'd0, 12'd0, 12'd0);
		for (int i = 0; i < WDOG_TICKS; i++)
			send_word(CMD_TICK, 4'd0, 12'd0, 12'd0, 12'd0);
		settle();

		$display("Covered %0d input words and %0d result words, %0d of them limp events,",
			word_count, result_count, limp_count);
		$display("over %0d register settings, ending with channel 0 pinned at a limit.",
			settings + 1);
		if (fail_count == 0 && pending == 0)
			$display("servo_slew_limiter_watchdog_test passed");
		else
			$display("servo_slew_limiter_watchdog_test failed");
		$finish;
	end

endmodule
